@@ rtl/bpp_pkg.sv @@
// Package for the 2D Boris particle pusher: grid sizes, command and register
// codes, divider request/response types and saturating helpers.
// No dependencies.
package bpp_pkg;

  localparam int GRID_X = 64;
  localparam int GRID_Y = 64;
  localparam int DEPTH  = GRID_X * GRID_Y;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IW     = $clog2(GRID_X);
  localparam int JW     = $clog2(GRID_Y);
  localparam int CNT_W  = 7;
  localparam int CELLS_X_RST = (64 > GRID_X) ? GRID_X : 64;
  localparam int CELLS_Y_RST = (64 > GRID_Y) ? GRID_Y : 64;

  localparam int DIV_NW = 49;
  localparam int DIV_DW = 38;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_PUSH  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_QM      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CELL_W  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CELL_H  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CELLS_X = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CELLS_Y = 3'd4;

  typedef struct packed {
    logic                     go;
    logic signed [DIV_NW-1:0] num;
    logic        [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DIV_NW-1:0] quot;
    logic        [DIV_DW-1:0] rem;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32w(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -68'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input logic sub);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
    if (s[32] != s[31]) r = s[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    else r = s[31:0];
    return r;
  endfunction

  // single periodic wrap, then saturate
  function automatic logic signed [31:0] wrap_once(input logic signed [32:0] n,
                                                   input logic [DIV_DW-1:0] l);
    logic signed [39:0] ne;
    logic signed [39:0] le;
    logic signed [39:0] r;
    ne = 40'(n);
    le = $signed({2'b00, l});
    if (ne < 0) r = ne + le;
    else if (ne >= le) r = ne - le;
    else r = ne;
    return sat32w(68'(r));
  endfunction

  function automatic logic signed [31:0] sat_rem(input logic [DIV_DW-1:0] v);
    logic signed [31:0] r;
    if (v > DIV_DW'(32'h7FFFFFFF)) r = 32'sh7FFFFFFF;
    else r = $signed(v[31:0]);
    return r;
  endfunction

endpackage

@@ rtl/bpp_if.sv @@
// Handshake channel interfaces of the particle pusher: input items, result
// items and configuration writes. Uses bpp_pkg.
interface bpp_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  cmd;
  logic        [5:0]  cell_x;
  logic        [5:0]  cell_y;
  logic signed [31:0] field_ex;
  logic signed [31:0] field_ey;
  logic signed [31:0] field_bz;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_vx;
  logic signed [31:0] start_vy;
  logic signed [31:0] start_time;
  logic        [30:0] time_step;
  modport source (output valid, cmd, cell_x, cell_y, field_ex, field_ey, field_bz,
                  start_x, start_y, start_vx, start_vy, start_time, time_step,
                  input ready);
  modport sink (input valid, cmd, cell_x, cell_y, field_ex, field_ey, field_bz,
                start_x, start_y, start_vx, start_vy, start_time, time_step,
                output ready);
endinterface

interface bpp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] sim_time;
  modport source (output valid, pos_x, pos_y, vel_x, vel_y, sim_time, input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, sim_time, output ready);
endinterface

interface bpp_cfg_if;
  import bpp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/boris_particle_push_2d_unit.sv @@
// Top level of the 2D Boris particle pusher: field grid memories, particle
// state and the sequencer around one shared multiplier. Uses bpp_pkg,
// bpp_if and bpp_div.
//
// Usage: in_ch carries one command item (write a field cell, push one step,
// initialise the particle, or no-op); every item yields exactly one result on
// out_ch, the particle state after it. cfg_ch writes q/m, cell spacing and
// cell counts; it is always ready and must only be used while idle.
// One item at a time: in_ch.ready is high only when idle, and is held low
// until the result has been taken, so a stalled receiver simply holds the
// result and stalls the input.
// The result is held valid in S_DONE, and the block returns to idle once it
// has been taken. A push is dominated by five divisions in the shared
// bit-serial divider (49 quotient bits each), then 12 grid reads, 24
// multiply-accumulates for interpolation and 13 multiplies for the kicks,
// rotation and move.
// Reset: particle state to zero, registers to their defaults; the field
// grid is not cleared and must be written before it is used.
module boris_particle_push_2d_unit (
  input  logic       clk,
  input  logic       rst_n,
  bpp_in_if.sink     in_ch,
  bpp_out_if.source  out_ch,
  bpp_cfg_if.sink    cfg_ch
);
  import bpp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_LEN, S_UX, S_IX, S_UY, S_JY, S_RD, S_INT,
    S_KICK, S_SDIV, S_ROT, S_INX, S_INY, S_DONE
  } state_t;

  state_t state_r;
  logic [3:0] step_r;
  logic [1:0] fld_r;
  logic       out_valid_r;

  // configuration
  logic signed [31:0] qm_r;
  logic [30:0]        cw_r;
  logic [30:0]        ch_r;
  logic [CNT_W-1:0]   ncx_r;
  logic [CNT_W-1:0]   ncy_r;

  // particle
  logic signed [31:0] px_r, py_r, vx_r, vy_r, time_r;

  // latched item
  logic [1:0]         cmd_r;
  logic [5:0]         cell_x_r, cell_y_r;
  logic signed [31:0] fex_r, fey_r, fbz_r;
  logic signed [31:0] sx_r, sy_r, svx_r, svy_r, st_r;
  logic [30:0]        dt_r;

  // working registers
  logic [DIV_DW-1:0]  lx_r, ly_r;
  logic [15:0]        wx_r, wy_r;
  logic [IW-1:0]      i0_r, i1_r;
  logic [JW-1:0]      j0_r, j1_r;
  logic signed [31:0] f_r [3][4];
  logic signed [31:0] e_r [3];
  logic signed [48:0] lo_r, hi_r;
  logic signed [31:0] kx_r, ky_r, tz_r, sz_r;
  logic signed [31:0] vmx_r, vmy_r, vpx_r, vpy_r, vqx_r, vqy_r;
  logic signed [32:0] nx_r, ny_r;
  logic signed [67:0] acc_r;

  div_req_t div_req_r;
  div_rsp_t div_rsp;

  bpp_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req_r),
    .rsp (div_rsp)
  );

  // field memories
  logic signed [31:0] ex_mem [DEPTH];
  logic signed [31:0] ey_mem [DEPTH];
  logic signed [31:0] bz_mem [DEPTH];
  logic signed [31:0] ex_rd_r, ey_rd_r, bz_rd_r;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic               mem_we;
  logic [IW-1:0]      ii;
  logic [JW-1:0]      jj;

  assign mem_we  = (state_r == S_WRITE) && (int'(cell_x_r) < GRID_X)
                   && (int'(cell_y_r) < GRID_Y);
  assign wr_addr = ADDR_W'(cell_y_r) * ADDR_W'(GRID_X) + ADDR_W'(cell_x_r);
  assign ii      = step_r[0] ? i1_r : i0_r;
  assign jj      = step_r[1] ? j1_r : j0_r;
  assign rd_addr = ADDR_W'(jj) * ADDR_W'(GRID_X) + ADDR_W'(ii);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ex_mem[wr_addr] <= fex_r;
      ey_mem[wr_addr] <= fey_r;
      bz_mem[wr_addr] <= fbz_r;
    end
    ex_rd_r <= ex_mem[rd_addr];
    ey_rd_r <= ey_mem[rd_addr];
    bz_rd_r <= bz_mem[rd_addr];
  end

  // shared multiplier
  logic signed [33:0] mul_a, mul_b;
  logic               mul_sh, mul_clr;
  logic signed [67:0] prod, term, acc_nxt;
  logic signed [31:0] s16, s17, f_sel;
  logic [16:0]        wxn, wyn;

  assign s16   = sat32w(acc_r >>> 16);
  assign s17   = sat32w(acc_r >>> 17);
  assign f_sel = f_r[fld_r][step_r[1:0]];
  assign wxn   = 17'd65536 - {1'b0, wx_r};
  assign wyn   = 17'd65536 - {1'b0, wy_r};

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_sh  = 1'b0;
    mul_clr = 1'b1;
    unique case (state_r)
      S_LEN: begin
        mul_a = step_r[0] ? 34'(ncy_r) : 34'(ncx_r);
        mul_b = step_r[0] ? 34'(ch_r) : 34'(cw_r);
      end
      S_INT: begin
        unique case (step_r[2:0])
          3'd0: begin mul_a = 34'(f_sel); mul_b = 34'(wxn); end
          3'd1: begin mul_a = 34'(f_sel); mul_b = 34'(wx_r); mul_clr = 1'b0; end
          3'd2: begin mul_a = 34'(f_sel); mul_b = 34'(wxn); end
          3'd3: begin mul_a = 34'(f_sel); mul_b = 34'(wx_r); mul_clr = 1'b0; end
          3'd4: begin
            mul_a = 34'($signed(lo_r[48:16])); mul_b = 34'(wyn); mul_sh = 1'b1;
          end
          3'd5: begin mul_a = 34'(lo_r[15:0]); mul_b = 34'(wyn); mul_clr = 1'b0; end
          3'd6: begin
            mul_a = 34'($signed(hi_r[48:16])); mul_b = 34'(wy_r);
            mul_sh = 1'b1; mul_clr = 1'b0;
          end
          default: begin mul_a = 34'(hi_r[15:0]); mul_b = 34'(wy_r); mul_clr = 1'b0; end
        endcase
      end
      S_KICK: begin
        unique case (step_r)
          4'd0: begin mul_a = 34'(qm_r); mul_b = 34'(e_r[0]); end
          4'd2: begin mul_a = 34'(qm_r); mul_b = 34'(e_r[1]); end
          4'd4: begin mul_a = 34'(qm_r); mul_b = 34'(e_r[2]); end
          4'd1, 4'd3, 4'd5: begin mul_a = 34'(s16); mul_b = 34'(dt_r); end
          4'd6: begin mul_a = 34'(s17); mul_b = 34'(s17); end
          default: ;
        endcase
      end
      S_ROT: begin
        unique case (step_r)
          4'd0: begin mul_a = 34'(vmy_r); mul_b = 34'(tz_r); end
          4'd1: begin mul_a = 34'(vmx_r); mul_b = 34'(tz_r); end
          4'd3: begin mul_a = 34'(vpy_r); mul_b = 34'(sz_r); end
          4'd4: begin mul_a = 34'(vpx_r); mul_b = 34'(sz_r); end
          4'd7: begin mul_a = 34'(vx_r); mul_b = 34'(dt_r); end
          4'd8: begin mul_a = 34'(vy_r); mul_b = 34'(dt_r); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign term    = mul_sh ? (prod <<< 16) : prod;
  assign acc_nxt = mul_clr ? term : acc_r + term;

  // next periodic index
  logic [CNT_W-1:0] i_inc, j_inc;
  assign i_inc = CNT_W'(div_rsp.rem[IW-1:0]) + 1'b1;
  assign j_inc = CNT_W'(div_rsp.rem[JW-1:0]) + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= '0;
      fld_r        <= '0;
      out_valid_r  <= 1'b0;
      div_req_r.go <= 1'b0;
      px_r   <= '0;
      py_r   <= '0;
      vx_r   <= '0;
      vy_r   <= '0;
      time_r <= '0;
      qm_r   <= 32'sd65536;
      cw_r   <= 31'd65536;
      ch_r   <= 31'd65536;
      ncx_r  <= CNT_W'(CELLS_X_RST);
      ncy_r  <= CNT_W'(CELLS_Y_RST);
    end else begin
      div_req_r.go <= 1'b0;
      acc_r        <= acc_nxt;

      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_QM:     qm_r <= $signed(cfg_ch.data);
          REG_CELL_W: cw_r <= (cfg_ch.data[30:0] == '0) ? 31'd1 : cfg_ch.data[30:0];
          REG_CELL_H: ch_r <= (cfg_ch.data[30:0] == '0) ? 31'd1 : cfg_ch.data[30:0];
          REG_CELLS_X: begin
            if (cfg_ch.data[6:0] == '0) ncx_r <= CNT_W'(1);
            else if (int'(cfg_ch.data[6:0]) > GRID_X) ncx_r <= CNT_W'(GRID_X);
            else ncx_r <= cfg_ch.data[6:0];
          end
          REG_CELLS_Y: begin
            if (cfg_ch.data[6:0] == '0) ncy_r <= CNT_W'(1);
            else if (int'(cfg_ch.data[6:0]) > GRID_Y) ncy_r <= CNT_W'(GRID_Y);
            else ncy_r <= cfg_ch.data[6:0];
          end
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_r    <= in_ch.cmd;
            cell_x_r <= in_ch.cell_x;
            cell_y_r <= in_ch.cell_y;
            fex_r    <= in_ch.field_ex;
            fey_r    <= in_ch.field_ey;
            fbz_r    <= in_ch.field_bz;
            sx_r     <= in_ch.start_x;
            sy_r     <= in_ch.start_y;
            svx_r    <= in_ch.start_vx;
            svy_r    <= in_ch.start_vy;
            st_r     <= in_ch.start_time;
            dt_r     <= in_ch.time_step;
            step_r   <= '0;
            unique case (in_ch.cmd)
              CMD_WRITE: state_r <= S_WRITE;
              CMD_PUSH, CMD_INIT: state_r <= S_LEN;
              default: begin
                state_r     <= S_DONE;
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        S_WRITE: begin
          state_r     <= S_DONE;
          out_valid_r <= 1'b1;
        end
        S_LEN: begin
          step_r <= step_r + 1'b1;
          if (step_r == 4'd1) lx_r <= acc_r[DIV_DW-1:0];
          if (step_r == 4'd2) begin
            ly_r         <= acc_r[DIV_DW-1:0];
            step_r       <= '0;
            div_req_r.go <= 1'b1;
            if (cmd_r == CMD_PUSH) begin
              div_req_r.num <= $signed({px_r[31], px_r, 16'd0});
              div_req_r.den <= {7'd0, cw_r};
              state_r       <= S_UX;
            end else begin
              div_req_r.num <= 49'(sx_r);
              div_req_r.den <= lx_r;
              state_r       <= S_INX;
            end
          end
        end
        S_UX: begin
          if (div_rsp.done) begin
            wx_r          <= div_rsp.quot[15:0];
            div_req_r.go  <= 1'b1;
            div_req_r.num <= 49'($signed(div_rsp.quot[48:16]));
            div_req_r.den <= DIV_DW'(ncx_r);
            state_r       <= S_IX;
          end
        end
        S_IX: begin
          if (div_rsp.done) begin
            i0_r          <= div_rsp.rem[IW-1:0];
            i1_r          <= (i_inc == ncx_r) ? '0 : i_inc[IW-1:0];
            div_req_r.go  <= 1'b1;
            div_req_r.num <= $signed({py_r[31], py_r, 16'd0});
            div_req_r.den <= {7'd0, ch_r};
            state_r       <= S_UY;
          end
        end
        S_UY: begin
          if (div_rsp.done) begin
            wy_r          <= div_rsp.quot[15:0];
            div_req_r.go  <= 1'b1;
            div_req_r.num <= 49'($signed(div_rsp.quot[48:16]));
            div_req_r.den <= DIV_DW'(ncy_r);
            state_r       <= S_JY;
          end
        end
        S_JY: begin
          if (div_rsp.done) begin
            j0_r    <= div_rsp.rem[JW-1:0];
            j1_r    <= (j_inc == ncy_r) ? '0 : j_inc[JW-1:0];
            step_r  <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          step_r <= step_r + 1'b1;
          if (step_r != 4'd0) begin
            f_r[0][2'(step_r - 1'b1)] <= ex_rd_r;
            f_r[1][2'(step_r - 1'b1)] <= ey_rd_r;
            f_r[2][2'(step_r - 1'b1)] <= bz_rd_r;
          end
          if (step_r == 4'd4) begin
            step_r  <= '0;
            fld_r   <= '0;
            state_r <= S_INT;
          end
        end
        S_INT: begin
          step_r <= step_r + 1'b1;
          if (step_r == 4'd1) lo_r <= acc_nxt[48:0];
          if (step_r == 4'd3) hi_r <= acc_nxt[48:0];
          if (step_r == 4'd7) begin
            e_r[fld_r] <= acc_nxt[63:32];
            step_r     <= '0;
            if (fld_r == 2'd2) begin
              fld_r   <= '0;
              state_r <= S_KICK;
            end else begin
              fld_r <= fld_r + 1'b1;
            end
          end
        end
        S_KICK: begin
          step_r <= step_r + 1'b1;
          if (step_r == 4'd2) kx_r <= s17;
          if (step_r == 4'd4) ky_r <= s17;
          if (step_r == 4'd6) tz_r <= s17;
          if (step_r == 4'd7) begin
            vmx_r         <= sat_add(vx_r, kx_r, 1'b0);
            vmy_r         <= sat_add(vy_r, ky_r, 1'b0);
            div_req_r.go  <= 1'b1;
            div_req_r.num <= $signed({tz_r, 17'd0});
            div_req_r.den <= DIV_DW'({1'b0, s16} + 33'd65536);
            step_r        <= '0;
            state_r       <= S_SDIV;
          end
        end
        S_SDIV: begin
          if (div_rsp.done) begin
            sz_r    <= div_rsp.quot[31:0];
            step_r  <= '0;
            state_r <= S_ROT;
          end
        end
        S_ROT: begin
          step_r <= step_r + 1'b1;
          unique case (step_r)
            4'd1: vpx_r <= sat_add(vmx_r, s16, 1'b0);
            4'd2: vpy_r <= sat_add(vmy_r, s16, 1'b1);
            4'd4: vqx_r <= sat_add(vmx_r, s16, 1'b0);
            4'd5: vqy_r <= sat_add(vmy_r, s16, 1'b1);
            4'd6: begin
              vx_r <= sat_add(vqx_r, kx_r, 1'b0);
              vy_r <= sat_add(vqy_r, ky_r, 1'b0);
            end
            4'd8: nx_r <= {px_r[31], px_r} + {s16[31], s16};
            4'd9: ny_r <= {py_r[31], py_r} + {s16[31], s16};
            4'd10: begin
              px_r        <= wrap_once(nx_r, lx_r);
              py_r        <= wrap_once(ny_r, ly_r);
              time_r      <= sat_add(time_r, $signed({1'b0, dt_r}), 1'b0);
              step_r      <= '0;
              state_r     <= S_DONE;
              out_valid_r <= 1'b1;
            end
            default: ;
          endcase
        end
        S_INX: begin
          if (div_rsp.done) begin
            px_r          <= sat_rem(div_rsp.rem);
            div_req_r.go  <= 1'b1;
            div_req_r.num <= 49'(sy_r);
            div_req_r.den <= ly_r;
            state_r       <= S_INY;
          end
        end
        S_INY: begin
          if (div_rsp.done) begin
            py_r        <= sat_rem(div_rsp.rem);
            vx_r        <= svx_r;
            vy_r        <= svy_r;
            time_r      <= st_r;
            state_r     <= S_DONE;
            out_valid_r <= 1'b1;
          end
        end
        S_DONE: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready     = (state_r == S_IDLE);
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.pos_x    = px_r;
  assign out_ch.pos_y    = py_r;
  assign out_ch.vel_x    = vx_r;
  assign out_ch.vel_y    = vy_r;
  assign out_ch.sim_time = time_r;

endmodule

@@ rtl/bpp_div.sv @@
// Bit-serial signed floor divider: floor quotient and non-negative remainder
// for a positive divisor, one quotient bit per cycle. Uses bpp_pkg.
module bpp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  bpp_pkg::div_req_t  req,
  output bpp_pkg::div_rsp_t  rsp
);
  import bpp_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_t;

  dstate_t                  dst_r;
  logic [DIV_CW-1:0]        cnt_r;
  logic                     neg_r;
  logic [DIV_NW-1:0]        mag_r;
  logic [DIV_NW-1:0]        q_r;
  logic [DIV_DW-1:0]        r_r;
  logic [DIV_DW-1:0]        den_r;
  logic signed [DIV_NW-1:0] quot_r;
  logic [DIV_DW-1:0]        rem_r;
  logic                     done_r;

  logic [DIV_DW:0] trial;
  logic [DIV_DW:0] diff;
  logic            fits;

  assign trial = {r_r, mag_r[DIV_NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dst_r  <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (dst_r)
        D_IDLE: begin
          if (req.go) begin
            neg_r <= req.num[DIV_NW-1];
            mag_r <= req.num[DIV_NW-1] ? DIV_NW'(-req.num) : DIV_NW'(req.num);
            den_r <= req.den;
            q_r   <= '0;
            r_r   <= '0;
            cnt_r <= DIV_CW'(DIV_NW);
            dst_r <= D_RUN;
          end
        end
        D_RUN: begin
          r_r   <= fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
          q_r   <= {q_r[DIV_NW-2:0], fits};
          mag_r <= {mag_r[DIV_NW-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == DIV_CW'(1)) dst_r <= D_FIX;
        end
        D_FIX: begin
          if (neg_r) quot_r <= (r_r != '0) ? $signed(~q_r) : $signed(-q_r);
          else quot_r <= $signed(q_r);
          rem_r  <= (neg_r && r_r != '0) ? den_r - r_r : r_r;
          done_r <= 1'b1;
          dst_r  <= D_IDLE;
        end
        default: dst_r <= D_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule
